@@ sv/smft_pkg.sv @@
package smft_pkg;

    localparam int VAL_W            = 31;
    localparam int DATA_W           = 32;
    localparam int STATUS_W         = 2;
    localparam int CAPACITY_DEFAULT = 256;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // per-cell compare results shown to the neighbors
    typedef struct packed {
        logic ins_after;   // cell is at or past the insert slot
        logic take_hit;    // cell holds a value at or below the limit
    } smft_flags_t;

    // command broadcast to every cell
    typedef struct packed {
        logic load;        // a request is accepted this cycle
        logic do_insert;   // insert that will be stored
        logic do_take;     // take that finds a value
    } smft_cmd_t;

endpackage

@@ sv/sorted_multiset_floor_take_core.sv @@
// Sorted multiset with floor-take. Each request is an insert (s_tuser = 0)
// of a 31-bit value, kept in ascending order with duplicates placed after
// equal values, or a take (s_tuser = 1) that removes and returns one copy of
// the largest stored value not above the limit. Every request gives exactly
// one response: status on m_tuser (0 done, 1 nothing at or below the limit,
// 2 store full on insert) and the taken value on m_tdata, zero unless a take
// succeeded. The store is a row of CAPACITY cells; all cells compare the
// request value in parallel and shift to their neighbor in the accept cycle.
// The taken value is gathered by a registered OR tree of clog2(CAPACITY)
// levels behind the per-cell leaf registers, and m_tvalid rises once the
// value has passed the leaf registers and every tree level. s_tready
// returns the cycle after the response is accepted, so a new request is
// taken only once the response to the last one has been accepted, and
// holding m_tready low delays it further.
// The store is empty after reset; no clearing pass is needed.
module sorted_multiset_floor_take_core #(
    parameter int CAPACITY = smft_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [30:0] item_value, [31] zero fill
    input  logic [0:0]  s_tuser,    // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [30:0] taken_value, [31] zero fill
    output logic [1:0]  m_tuser     // [1:0] status
);
    import smft_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int WW     = $clog2(LEVELS + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                busy_reg;
    logic [WW-1:0]       wait_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                accept;
    logic                resp_done;
    logic                full;
    logic                any_hit;
    logic                is_take;
    logic [VAL_W-1:0]    item_value;
    smft_cmd_t           cmd;

    logic [VAL_W-1:0]    cell_val   [CAPACITY];
    smft_flags_t         cell_flags [CAPACITY];
    logic [VAL_W-1:0]    cell_leaf  [CAPACITY];
    logic [VAL_W-1:0]    root;

    assign item_value = s_tdata[VAL_W-1:0];
    assign is_take    = (s_tuser[0] == OP_TAKE);
    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign full       = (count_reg == CW'(CAPACITY));
    // cell 0 sees a hit whenever any stored value is at or below the limit
    assign any_hit    = cell_flags[0].take_hit;

    assign cmd.load      = accept;
    assign cmd.do_insert = accept && !is_take && !full;
    assign cmd.do_take   = accept && is_take && any_hit;

    // cell row: values flow right on insert, left on take
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] lv;
        smft_flags_t      lf;
        logic [VAL_W-1:0] rv;
        smft_flags_t      rf;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lf = '0;
        end
        else
        begin : g_mid_l
            assign lv = cell_val[i-1];
            assign lf = cell_flags[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = cell_val[i];
            assign rf = '0;
        end
        else
        begin : g_mid_r
            assign rv = cell_val[i+1];
            assign rf = cell_flags[i+1];
        end

        smft_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CW'(i) < count_reg),
            .item_value  (item_value),
            .left_val    (lv),
            .left_flags  (lf),
            .right_val   (rv),
            .right_flags (rf),
            .val         (cell_val[i]),
            .flags       (cell_flags[i]),
            .leaf        (cell_leaf[i])
        );
    end

    // only the removed cell puts a nonzero leaf, so OR picks it out
    smft_or_tree #(
        .CAPACITY (CAPACITY)
    ) u_tree (
        .clk    (clk),
        .leaves (cell_leaf),
        .root   (root)
    );

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        if (cmd.do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.do_take)
        begin
            count_next = count_reg - 1'b1;
        end
        if (!is_take && full)
        begin
            status_next = ST_FULL;
        end
        else if (is_take && !any_hit)
        begin
            status_next = ST_NONE;
        end
    end

    assign resp_done = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            wait_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
                wait_reg <= WW'(LEVELS);
            end
            else
            begin
                if (wait_reg != '0)
                begin
                    wait_reg <= wait_reg - 1'b1;
                end
                if (resp_done)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // response is ready once the tree has drained down to the root
    assign m_tvalid = busy_reg && (wait_reg == '0);
    assign m_tdata  = {{(DATA_W - VAL_W){1'b0}}, root};
    assign m_tuser  = status_reg;

endmodule

@@ sv/smft_cell.sv @@
module smft_cell (
    input  logic                         clk,
    input  smft_pkg::smft_cmd_t          cmd,
    input  logic                         occupied,
    input  logic [smft_pkg::VAL_W-1:0]   item_value,
    input  logic [smft_pkg::VAL_W-1:0]   left_val,
    input  smft_pkg::smft_flags_t        left_flags,
    input  logic [smft_pkg::VAL_W-1:0]   right_val,
    input  smft_pkg::smft_flags_t        right_flags,
    output logic [smft_pkg::VAL_W-1:0]   val,
    output smft_pkg::smft_flags_t        flags,
    output logic [smft_pkg::VAL_W-1:0]   leaf
);
    import smft_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [VAL_W-1:0] leaf_reg;
    logic [VAL_W-1:0] leaf_next;
    logic             gt;
    logic             is_idx;

    assign gt              = val_reg > item_value;
    assign flags.ins_after = !occupied || gt;
    assign flags.take_hit  = occupied && !gt;

    // last cell at or below the limit holds the value to take
    assign is_idx = flags.take_hit && !right_flags.take_hit;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.do_insert && flags.ins_after)
        begin
            val_next = left_flags.ins_after ? left_val : item_value;
        end
        else if (cmd.do_take && (is_idx || !flags.take_hit))
        begin
            val_next = right_val;
        end
    end

    assign leaf_next = (cmd.do_take && is_idx) ? val_reg : '0;

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (cmd.load)
        begin
            leaf_reg <= leaf_next;
        end
    end

    assign val  = val_reg;
    assign leaf = leaf_reg;

endmodule

@@ sv/smft_or_tree.sv @@
module smft_or_tree #(
    parameter int CAPACITY = smft_pkg::CAPACITY_DEFAULT
) (
    input  logic                         clk,
    input  logic [smft_pkg::VAL_W-1:0]   leaves [CAPACITY],
    output logic [smft_pkg::VAL_W-1:0]   root
);
    import smft_pkg::*;

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int P      = 1 << LEVELS;

    // heap-ordered nodes, node 1 is the root; one register per node
    logic [VAL_W-1:0] node_reg [1:P-1];

    always_ff @(posedge clk)
    begin
        for (int n = 1; n < P; n++)
        begin
            if (n < P / 2)
            begin
                node_reg[n] <= node_reg[2*n] | node_reg[2*n+1];
            end
            else
            begin
                node_reg[n] <= ((2*n - P < CAPACITY) ? leaves[2*n - P] : '0)
                             | ((2*n + 1 - P < CAPACITY) ? leaves[2*n + 1 - P] : '0);
            end
        end
    end

    assign root = node_reg[1];

endmodule

@@ tb/sorted_multiset_floor_take_core_test.sv @@
`timescale 1ns / 1ps

module sorted_multiset_floor_take_core_test;
    import smft_pkg::*;

    localparam int CAP        = CAPACITY_DEFAULT;
    localparam int IDLE_LIMIT = 3000;   // cycles with no request or response moving
    localparam int DRAIN_WAIT = 20;     // OR tree is clog2(CAP) deep; allow margin
    localparam int DIR_ROWS   = 21;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    taken;
    } resp_t;

    // one directed request; 'typed' rows carry a hand-written response
    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] val;
        logic             typed;
        resp_t            resp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [30:0] item_value, [31] zero fill
    logic [0:0]  s_tuser;    // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [30:0] taken_value, [31] zero fill
    logic [1:0]  m_tuser;    // [1:0] status

    // predictor state: ascending copy of the store
    logic [VAL_W-1:0] shadow_store_q[$];
    // responses still owed by the block, oldest first
    resp_t            owed_resp_q[$];
    int               err_count;
    int               idle_cycles;
    bit               rx_enable;
    bit               eager_sender;   // no gaps while set
    dir_row_t         dir_table [DIR_ROWS];

    sorted_multiset_floor_take_core #(
        .CAPACITY (CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Floor-take predictor. Insert goes after equal values; take removes the
    // last entry that is not above the limit.
    function automatic resp_t floor_take_predict(input logic op, input logic [VAL_W-1:0] v);
        resp_t r;
        int    n_le;
        r.status = ST_DONE;
        r.taken  = '0;
        n_le     = 0;
        foreach (shadow_store_q[i])
            if (shadow_store_q[i] <= v)
                n_le++;
        if (op == OP_INSERT)
        begin
            if (shadow_store_q.size() >= CAP)
                r.status = ST_FULL;
            else
                shadow_store_q.insert(n_le, v);
        end
        else
        begin
            if (n_le == 0)
                r.status = ST_NONE;
            else
            begin
                r.taken = shadow_store_q[n_le-1];
                shadow_store_q.delete(n_le-1);
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Values: small ones collide and make duplicates, wide ones hit every bit.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return VAL_W'($urandom_range(0, 63));
        else if (roll == 4)
            return ($urandom_range(0, 1) != 0) ? VAL_MAX : '0;
        return VAL_W'($urandom());
    endfunction

    // Take limits: exact hits, just below a stored value, the top, or anything.
    function automatic logic [VAL_W-1:0] pick_limit();
        int               roll;
        logic [VAL_W-1:0] hit;
        roll = $urandom_range(0, 9);
        if (shadow_store_q.size() != 0 && roll < 5)
        begin
            hit = shadow_store_q[$urandom_range(0, shadow_store_q.size() - 1)];
            if (roll < 3 || hit == '0)
                return hit;
            return hit - 1'b1;
        end
        if (roll == 5)
            return VAL_MAX;
        return pick_value();
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic op, input logic [VAL_W-1:0] v,
                                input logic typed, input resp_t typed_resp);
        int    gap;
        resp_t predicted;
        gap = eager_sender ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, v};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = floor_take_predict(op, v);
        owed_resp_q.insert(owed_resp_q.size(), typed ? typed_resp : predicted);
        @(negedge clk);
    endtask

    task automatic send_random(input int insert_pct);
        logic op;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_TAKE;
        send_request(op, (op == OP_INSERT) ? pick_value() : pick_limit(), 1'b0, '0);
    endtask

    // Response side: long ready stretches, short stalls, rare long stalls.
    initial
    begin : rx_ready_gen
        int roll;
        m_tready = 1'b0;
        wait (rx_enable);
        forever
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
            begin
                m_tready = 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge clk);
            end
            else if (roll < 9)
            begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                m_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(20, 40)) @(negedge clk);
            end
        end
    end

    // Response checker: every accepted response against the oldest owed one.
    always @(posedge clk)
    begin : resp_check
        resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_resp_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected response, status %0d taken %0h",
                         $time, m_tuser, m_tdata[VAL_W-1:0]);
            end
            else
            begin
                want = owed_resp_q.pop_front();
                if (m_tuser !== want.status)
                begin
                    err_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata[VAL_W-1:0] !== want.taken)
                begin
                    err_count++;
                    $display("%0t: taken_value expected %0h, got %0h",
                             $time, want.taken, m_tdata[VAL_W-1:0]);
                end
            end
        end
    end

    // Watchdog: trips when neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        err_count    = 0;
        idle_cycles  = 0;
        rx_enable    = 1'b0;
        eager_sender = 1'b0;

        // Directed: empty store, extremes, duplicates, exact hits, one-below.
        dir_table = '{
            '{OP_TAKE,   '0,                   1'b1, '{ST_NONE, '0}},      // take from empty
            '{OP_TAKE,   VAL_MAX,              1'b1, '{ST_NONE, '0}},
            '{OP_INSERT, VAL_MAX,              1'b1, '{ST_DONE, '0}},
            '{OP_INSERT, VAL_MAX,              1'b1, '{ST_DONE, '0}},      // duplicate
            '{OP_TAKE,   VAL_MAX - 1'b1,       1'b1, '{ST_NONE, '0}},      // all above limit
            '{OP_INSERT, '0,                   1'b1, '{ST_DONE, '0}},
            '{OP_TAKE,   '0,                   1'b1, '{ST_DONE, '0}},      // takes the zero
            '{OP_TAKE,   '0,                   1'b1, '{ST_NONE, '0}},
            '{OP_TAKE,   VAL_MAX,              1'b1, '{ST_DONE, VAL_MAX}}, // one copy only
            '{OP_INSERT, 31'd5,                1'b0, '0},
            '{OP_INSERT, 31'd5,                1'b0, '0},
            '{OP_INSERT, 31'd3,                1'b0, '0},
            '{OP_TAKE,   31'd4,                1'b0, '0},
            '{OP_TAKE,   31'd6,                1'b0, '0},
            '{OP_INSERT, 31'h5555_5555,        1'b0, '0},
            '{OP_INSERT, 31'h2AAA_AAAA,        1'b0, '0},
            '{OP_TAKE,   31'h5555_5554,        1'b0, '0},
            '{OP_TAKE,   VAL_MAX - 1'b1,       1'b0, '0},
            '{OP_TAKE,   VAL_MAX,              1'b0, '0},
            '{OP_TAKE,   VAL_MAX,              1'b0, '0},
            '{OP_TAKE,   VAL_MAX,              1'b1, '{ST_NONE, '0}}       // empty again
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        rx_enable = 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
            send_request(dir_table[i].op, dir_table[i].val, dir_table[i].typed,
                         dir_table[i].resp);

        // Mixed traffic; the first stretch back to back.
        eager_sender = 1'b1;
        for (n = 0; n < 80; n++)
        begin
            if (n == 20)
                eager_sender = 1'b0;
            send_random(50);
        end

        // Hold the sender until every response has drained.
        s_tvalid = 1'b0;
        while (owed_resp_q.size() != 0)
            @(negedge clk);

        // Fill the store to capacity, then push on it while full.
        while (shadow_store_q.size() < CAP)
            send_random(95);
        for (n = 0; n < 15; n++)
            send_random(65);

        // Drain with mostly takes.
        for (n = 0; n < 50; n++)
            send_random(15);

        s_tvalid = 1'b0;
        while (owed_resp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
